/* sv/gcrm_pkg.sv */
// Shared types, codes and constants for the colour ramp mapper.
// No dependencies; imported by every module of the block.
package gcrm_pkg;

  localparam int MAX_LIMITS_DEF = 8;
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_STEPS      = 32;
  localparam int K_BITS         = 6;   // step within a segment, 0..MAX_STEPS
  localparam int RECIP_SHIFT    = 20;
  localparam int CFG_DW         = 6;

  localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
  localparam logic [23:0] COLOR_WHITE  = 24'hFF_FFFF;
  localparam logic [3:0]  RST_LIMIT_COUNT   = 4'd2;
  localparam logic [5:0]  RST_STRETCH_STEPS = 6'd5;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_MAP   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    METH_STRETCH = 2'd0,
    METH_UPPER   = 2'd1,
    METH_LOWER   = 2'd2
  } meth_e;

  typedef enum logic {
    CFG_LIMIT_COUNT   = 1'b0,
    CFG_STRETCH_STEPS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic               cmd;
    logic [2:0]         entry_index;
    logic signed [31:0] entry_limit;
    logic [7:0]         entry_red;
    logic [7:0]         entry_green;
    logic [7:0]         entry_blue;
    logic [1:0]         entry_method;
    logic signed [31:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] color_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_word_t;

  // ceil(2^20 / s): exact truncating quotient for dividends below 2^13
  function automatic logic [20:0] recip_q20(input logic [5:0] s);
    logic [20:0] r;
    case (s)
      6'd1:  r = 21'd1048576;
      6'd2:  r = 21'd524288;
      6'd3:  r = 21'd349526;
      6'd4:  r = 21'd262144;
      6'd5:  r = 21'd209716;
      6'd6:  r = 21'd174763;
      6'd7:  r = 21'd149797;
      6'd8:  r = 21'd131072;
      6'd9:  r = 21'd116509;
      6'd10: r = 21'd104858;
      6'd11: r = 21'd95326;
      6'd12: r = 21'd87382;
      6'd13: r = 21'd80660;
      6'd14: r = 21'd74899;
      6'd15: r = 21'd69906;
      6'd16: r = 21'd65536;
      6'd17: r = 21'd61681;
      6'd18: r = 21'd58255;
      6'd19: r = 21'd55189;
      6'd20: r = 21'd52429;
      6'd21: r = 21'd49933;
      6'd22: r = 21'd47663;
      6'd23: r = 21'd45591;
      6'd24: r = 21'd43691;
      6'd25: r = 21'd41944;
      6'd26: r = 21'd40330;
      6'd27: r = 21'd38837;
      6'd28: r = 21'd37450;
      6'd29: r = 21'd36158;
      6'd30: r = 21'd34953;
      6'd31: r = 21'd33826;
      6'd32: r = 21'd32768;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

/* sv/gcrm_front.sv */
// Limit/colour/method tables and segment search stage.
// Depends on gcrm_pkg.
module gcrm_front import gcrm_pkg::*; #(
  parameter int MAX_LIMITS = MAX_LIMITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IW = (MAX_LIMITS > 1) ? $clog2(MAX_LIMITS) : 1,
  localparam int CW = $clog2(MAX_LIMITS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  in_valid_i,
  input  in_word_t              in_word_i,
  input  logic [CW-1:0]         n_i,
  input  logic [5:0]            s_i,
  output logic                  valid_o,
  output logic                  stretch_o,
  output logic [VALUE_BITS-1:0] x_o,
  output logic [VALUE_BITS-1:0] d_o,
  output logic [IW-1:0]         p_o,
  output logic [CW-1:0]         cnt_o,
  output logic [23:0]           col_a_o,
  output logic [23:0]           col_b_o,
  output logic [5:0]            s_o
);

  localparam logic signed [VALUE_BITS-1:0] LIM_ONE = VALUE_BITS'(ONE_Q16);

  logic signed [VALUE_BITS-1:0] lim_q [MAX_LIMITS];
  logic [23:0]                  col_q [MAX_LIMITS];
  meth_e                        meth_q [MAX_LIMITS];

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  meth_e         wr_meth;

  assign wr_en  = in_valid_i && en_i && (in_word_i.cmd == CMD_WRITE) &&
                  (int'(in_word_i.entry_index) < MAX_LIMITS);
  assign wr_idx = IW'(in_word_i.entry_index);

  always_comb begin
    case (meth_e'(in_word_i.entry_method))
      METH_UPPER: wr_meth = METH_UPPER;
      METH_LOWER: wr_meth = METH_LOWER;
      default:    wr_meth = METH_STRETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_LIMITS; j++) begin
        lim_q[j]  <= '0;
        col_q[j]  <= '0;
        meth_q[j] <= METH_STRETCH;
      end
      lim_q[1] <= LIM_ONE;
      col_q[1] <= COLOR_WHITE;
    end else if (wr_en) begin
      lim_q[wr_idx]  <= $signed(VALUE_BITS'($unsigned(in_word_i.entry_limit)));
      col_q[wr_idx]  <= {in_word_i.entry_red, in_word_i.entry_green, in_word_i.entry_blue};
      meth_q[wr_idx] <= wr_meth;
    end
  end

  // search
  logic signed [VALUE_BITS-1:0] v;
  logic [MAX_LIMITS-1:0] lt, eq, seg;
  logic [CW-1:0] cnt_pre [MAX_LIMITS];
  logic found, below, above, eq_i;
  logic signed [VALUE_BITS-1:0] l0, l1;
  meth_e m_i;
  logic [23:0] ca_i, cb_i, c_top;
  logic [IW-1:0] p_i, p_i1, p_top;
  logic [CW-1:0] c_i, c_i1, cnt_top;

  logic              stretch_d;
  logic [VALUE_BITS-1:0] x_d, d_d;
  logic [IW-1:0]     p_d;
  logic [CW-1:0]     cnt_d;
  logic [23:0]       ca_d, cb_d;

  assign v = $signed(VALUE_BITS'($unsigned(in_word_i.sample_value)));

  always_comb begin
    for (int j = 0; j < MAX_LIMITS; j++) begin
      lt[j] = lim_q[j] < v;
      eq[j] = lim_q[j] == v;
    end
    cnt_pre[0] = '0;
    for (int j = 1; j < MAX_LIMITS; j++) begin
      cnt_pre[j] = cnt_pre[j-1] + CW'(meth_q[j-1] == METH_STRETCH);
    end
    // first segment whose upper limit is not below the sample
    found = 1'b0;
    seg   = '0;
    for (int j = 0; j < MAX_LIMITS - 1; j++) begin
      if (!found && (j < int'(n_i) - 1) && ((j == int'(n_i) - 2) || !lt[j+1])) begin
        seg[j] = 1'b1;
        found  = 1'b1;
      end
    end
    l0 = '0; l1 = '0; m_i = METH_STRETCH; ca_i = '0; cb_i = '0; eq_i = 1'b0;
    p_i = '0; p_i1 = '0; c_i = '0; c_i1 = '0;
    for (int j = 0; j < MAX_LIMITS - 1; j++) begin
      if (seg[j]) begin
        l0   = lim_q[j];
        l1   = lim_q[j+1];
        m_i  = meth_q[j];
        ca_i = col_q[j];
        cb_i = col_q[j+1];
        eq_i = eq[j];
        p_i  = IW'(j);
        p_i1 = IW'(j + 1);
        c_i  = cnt_pre[j];
        c_i1 = cnt_pre[j+1];
      end
    end
    above = 1'b0; c_top = '0; p_top = '0; cnt_top = '0;
    for (int j = 0; j < MAX_LIMITS; j++) begin
      if (j == int'(n_i) - 1) begin
        above   = lt[j];
        c_top   = col_q[j];
        p_top   = IW'(j);
        cnt_top = cnt_pre[j];
      end
    end
    below = !(lt[0] || eq[0]);

    stretch_d = 1'b0;
    x_d       = '0;
    d_d       = '0;
    if (below) begin
      p_d = '0; cnt_d = '0; ca_d = col_q[0]; cb_d = col_q[0];
    end else if (above) begin
      p_d = p_top; cnt_d = cnt_top; ca_d = c_top; cb_d = c_top;
    end else if (eq_i) begin
      p_d = p_i; cnt_d = c_i; ca_d = ca_i; cb_d = ca_i;
    end else begin
      case (m_i)
        METH_UPPER: begin
          p_d = p_i1; cnt_d = c_i1; ca_d = cb_i; cb_d = cb_i;
        end
        METH_LOWER: begin
          p_d = p_i; cnt_d = c_i; ca_d = ca_i; cb_d = ca_i;
        end
        default: begin
          p_d = p_i; cnt_d = c_i; ca_d = ca_i; cb_d = cb_i;
          stretch_d = 1'b1;
          x_d = $unsigned(v - l0);
          d_d = $unsigned(l1 - l0);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= in_valid_i && (in_word_i.cmd == CMD_MAP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stretch_o <= stretch_d;
      x_o       <= x_d;
      d_o       <= d_d;
      p_o       <= p_d;
      cnt_o     <= cnt_d;
      col_a_o   <= ca_d;
      col_b_o   <= cb_d;
      s_o       <= s_i;
    end
  end

endmodule

/* sv/gcrm_div.sv */
// Step-within-segment divider: floor((2*S*x + d) / (2*d)), one quotient bit a stage.
// Depends on gcrm_pkg.
module gcrm_div import gcrm_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int SIDE_W     = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic                  stretch_i,
  input  logic [VALUE_BITS-1:0] x_i,
  input  logic [VALUE_BITS-1:0] d_i,
  input  logic [5:0]            s_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [K_BITS-1:0]     k_o,
  output logic [5:0]            s_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int NW = VALUE_BITS + 8;
  localparam int DW = VALUE_BITS + 1;

  logic              vld_q  [K_BITS+1];
  logic [NW-1:0]     rem_q  [K_BITS+1];
  logic [DW-1:0]     den_q  [K_BITS+1];
  logic [K_BITS-1:0] quo_q  [K_BITS+1];
  logic [5:0]        s_q    [K_BITS+1];
  logic [SIDE_W-1:0] side_q [K_BITS+1];

  // numerator and divisor; non-stretch words divide 0 by 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= stretch_i ? ((NW'(s_i) * NW'(x_i)) << 1) + NW'(d_i) : '0;
      den_q[0]  <= stretch_i ? {d_i, 1'b0} : DW'(1);
      quo_q[0]  <= '0;
      s_q[0]    <= s_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar t = 0; t < K_BITS; t++) begin : g_stage
    localparam int B = K_BITS - 1 - t;
    logic [NW-1:0]     trial;
    logic              take;
    logic [NW-1:0]     rem_d;
    logic [K_BITS-1:0] quo_d;

    always_comb begin
      trial = NW'(den_q[t]) << B;
      take  = rem_q[t] >= trial;
      rem_d = take ? rem_q[t] - trial : rem_q[t];
      quo_d = quo_q[t];
      quo_d[B] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[t+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[t+1] <= vld_q[t];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[t+1]  <= rem_d;
        den_q[t+1]  <= den_q[t];
        quo_q[t+1]  <= quo_d;
        s_q[t+1]    <= s_q[t];
        side_q[t+1] <= side_q[t];
      end
    end
  end

  assign valid_o = vld_q[K_BITS];
  assign k_o     = quo_q[K_BITS];
  assign s_o     = s_q[K_BITS];
  assign side_o  = side_q[K_BITS];

endmodule

/* sv/gcrm_blend.sv */
// Step index and per-channel colour interpolation, ending in the output register.
// Depends on gcrm_pkg.
module gcrm_blend import gcrm_pkg::*; #(
  parameter int MAX_LIMITS = MAX_LIMITS_DEF,
  localparam int IW = (MAX_LIMITS > 1) ? $clog2(MAX_LIMITS) : 1,
  localparam int CW = $clog2(MAX_LIMITS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [K_BITS-1:0] k_i,
  input  logic [5:0]        s_i,
  input  logic [IW-1:0]     p_i,
  input  logic [CW-1:0]     cnt_i,
  input  logic [23:0]       col_a_i,
  input  logic [23:0]       col_b_i,
  output logic              valid_o,
  output out_word_t         word_o
);

  localparam int IDW = $clog2((MAX_LIMITS - 1) * MAX_STEPS + 2);
  localparam int RW  = (IDW > 9) ? IDW : 9;

  logic              v1_q;
  logic [RW-1:0]     r_q;
  logic [12:0]       mag_q [3];
  logic              neg_q [3];
  logic [7:0]        ca_q  [3];
  logic [5:0]        s1_q;

  logic [RW-1:0]     r_d;
  logic [12:0]       mag_d [3];
  logic              neg_d [3];
  logic signed [15:0] prod [3];
  logic signed [8:0]  diff [3];

  always_comb begin
    r_d = RW'(1) + RW'(p_i) + RW'(s_i - 6'd1) * RW'(cnt_i) + RW'(k_i);
    for (int c = 0; c < 3; c++) begin
      diff[c]  = $signed({1'b0, col_b_i[8*c +: 8]}) - $signed({1'b0, col_a_i[8*c +: 8]});
      prod[c]  = 16'(diff[c]) * 16'($signed({1'b0, k_i}));
      neg_d[c] = prod[c] < 0;
      mag_d[c] = neg_d[c] ? 13'(-prod[c]) : 13'(prod[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q  <= r_d;
      s1_q <= s_i;
      for (int c = 0; c < 3; c++) begin
        mag_q[c] <= mag_d[c];
        neg_q[c] <= neg_d[c];
        ca_q[c]  <= col_a_i[8*c +: 8];
      end
    end
  end

  // division by S through a reciprocal, truncating toward zero
  logic [20:0]       rc;
  logic [33:0]       qp   [3];
  logic [7:0]        quot [3];
  logic signed [9:0] sum  [3];
  logic [7:0]        ch   [3];
  out_word_t         word_d;

  always_comb begin
    rc = recip_q20(s1_q);
    for (int c = 0; c < 3; c++) begin
      qp[c]   = 34'(mag_q[c]) * 34'(rc);
      quot[c] = qp[c][RECIP_SHIFT +: 8];
      sum[c]  = neg_q[c] ? $signed(10'(ca_q[c])) - $signed(10'(quot[c]))
                         : $signed(10'(ca_q[c])) + $signed(10'(quot[c]));
      if (sum[c] < 0) ch[c] = 8'd0;
      else if (sum[c] > 10'sd255) ch[c] = 8'hFF;
      else ch[c] = sum[c][7:0];
    end
    word_d.color_index = (r_q > RW'(255)) ? 8'hFF : r_q[7:0];
    word_d.out_red     = ch[2];
    word_d.out_green   = ch[1];
    word_d.out_blue    = ch[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_o <= word_d;
    end
  end

endmodule

/* sv/gradual_color_ramp_mapper.sv */
// Colour ramp mapper top level: config registers, stall control, pipeline.
// Depends on gcrm_pkg, gcrm_front, gcrm_div and gcrm_blend.
// Throughput: one word per cycle unless a held output word stalls the input; the
// ten-stage pipeline with a one-bit-a-stage divider sets the latency. A stalled
// result freezes every stage in place.
// Reset restores the limit, colour and method tables and the two registers.
module gradual_color_ramp_mapper import gcrm_pkg::*; #(
  parameter int MAX_LIMITS = MAX_LIMITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  localparam int IW     = (MAX_LIMITS > 1) ? $clog2(MAX_LIMITS) : 1;
  localparam int CW     = $clog2(MAX_LIMITS + 1);
  localparam int SIDE_W = IW + CW + 48;

  logic [3:0] limit_count_q;
  logic [5:0] stretch_steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_count_q   <= RST_LIMIT_COUNT;
      stretch_steps_q <= RST_STRETCH_STEPS;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LIMIT_COUNT:   limit_count_q   <= cfg_wdata_i[3:0];
        CFG_STRETCH_STEPS: stretch_steps_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] n_used;
  logic [5:0]    s_used;

  always_comb begin
    if (limit_count_q < 4'd2) n_used = CW'(2);
    else if (int'(limit_count_q) > MAX_LIMITS) n_used = CW'(MAX_LIMITS);
    else n_used = CW'(limit_count_q);
    if (stretch_steps_q == 6'd0) s_used = 6'd1;
    else if (int'(stretch_steps_q) > MAX_STEPS) s_used = 6'(MAX_STEPS);
    else s_used = stretch_steps_q;
  end

  // single enable: everything moves unless a finished word is held back
  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  logic                  f_valid, f_stretch;
  logic [VALUE_BITS-1:0] f_x, f_d;
  logic [IW-1:0]         f_p, b_p;
  logic [CW-1:0]         f_cnt, b_cnt;
  logic [23:0]           f_ca, f_cb, b_ca, b_cb;
  logic [5:0]            f_s, b_s;
  logic                  b_valid;
  logic [K_BITS-1:0]     b_k;
  logic [SIDE_W-1:0]     side_in, side_out;

  gcrm_front #(
    .MAX_LIMITS(MAX_LIMITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i, .rst_ni,
    .en_i      (en),
    .in_valid_i,
    .in_word_i,
    .n_i       (n_used),
    .s_i       (s_used),
    .valid_o   (f_valid),
    .stretch_o (f_stretch),
    .x_o       (f_x),
    .d_o       (f_d),
    .p_o       (f_p),
    .cnt_o     (f_cnt),
    .col_a_o   (f_ca),
    .col_b_o   (f_cb),
    .s_o       (f_s)
  );

  assign side_in = {f_p, f_cnt, f_ca, f_cb};

  gcrm_div #(
    .VALUE_BITS(VALUE_BITS),
    .SIDE_W    (SIDE_W)
  ) u_div (
    .clk_i, .rst_ni,
    .en_i      (en),
    .valid_i   (f_valid),
    .stretch_i (f_stretch),
    .x_i       (f_x),
    .d_i       (f_d),
    .s_i       (f_s),
    .side_i    (side_in),
    .valid_o   (b_valid),
    .k_o       (b_k),
    .s_o       (b_s),
    .side_o    (side_out)
  );

  assign {b_p, b_cnt, b_ca, b_cb} = side_out;

  gcrm_blend #(
    .MAX_LIMITS(MAX_LIMITS)
  ) u_blend (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (b_valid),
    .k_i     (b_k),
    .s_i     (b_s),
    .p_i     (b_p),
    .cnt_i   (b_cnt),
    .col_a_i (b_ca),
    .col_b_i (b_cb),
    .valid_o (out_valid_o),
    .word_o  (out_word_o)
  );

endmodule

/* sv/gcrm_checker.sv */
// Port-level checks for the colour ramp mapper, bound to the top level.
// Depends on gcrm_pkg and gradual_color_ramp_mapper.
module gcrm_checker import gcrm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_i,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_word_t out_word_i
);

  // a held word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_word_i))
    else $error("stalled output word changed");

  // input back-pressure only ever comes from a held output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i && out_stall_i)
    else $error("input stalled without output back-pressure");

  // step indices start at one
  a_index_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_word_i.color_index != 8'd0)
    else $error("zero colour index");

endmodule

bind gradual_color_ramp_mapper gcrm_checker u_gcrm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_i  (out_word_o)
);

/* tb/tb_gradual_color_ramp_mapper.sv */
// Self-checking regression for the colour ramp mapper top level.
// Depends on gcrm_pkg and gradual_color_ramp_mapper; predicts each map result.
`timescale 1ns / 100ps

module tb_gradual_color_ramp_mapper;
  import gcrm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;

  always #4 clk_i = ~clk_i;

  gradual_color_ramp_mapper dut (.*);

  // predictor state: limits kept sign-flipped so unsigned compare orders them
  logic [31:0] lim_q [8];
  logic [23:0] col_q [8];
  meth_e       meth_q [8];
  logic [3:0]  count_q;
  logic [5:0]  steps_q;

  out_word_t expected_colors[$];
  int mismatches = 0;
  int results_seen = 0;
  int maps_sent = 0;
  int writes_sent = 0;
  bit hold_rx = 1'b0;
  bit no_idle = 1'b0;
  // idle cycles before the next word; zero keeps valid high across words
  int gap_q = 1;

  function automatic out_word_t map_sample(logic [31:0] sv);
    int unsigned idx [8];
    int unsigned n, s, i, r, top, j;
    logic [31:0] v;
    longint unsigned d, x, k;
    logic [23:0] col, a, b;
    int nr, ca, df, c;
    out_word_t o;
    n = (count_q < 2) ? 2 : (count_q > 8 ? 8 : count_q);
    s = (steps_q < 1) ? 1 : (steps_q > MAX_STEPS ? MAX_STEPS : steps_q);
    idx[0] = 1;
    for (i = 1; i < n; i++) idx[i] = idx[i-1] + (meth_q[i-1] == METH_STRETCH ? s : 1);
    top = idx[n-1];
    v = sv ^ 32'h8000_0000;
    if (v < lim_q[0]) r = 1;
    else if (v > lim_q[n-1]) r = top;
    else begin
      i = 0;
      while (i + 2 < n && lim_q[i+1] < v) i++;
      if (lim_q[i] == v) r = idx[i];
      else if (meth_q[i] == METH_UPPER) r = idx[i+1];
      else if (meth_q[i] == METH_LOWER) r = idx[i];
      else begin
        d = longint'(lim_q[i+1]) - longint'(lim_q[i]);
        x = longint'(v) - longint'(lim_q[i]);
        k = (2 * s * x + d) / (2 * d);
        r = idx[i] + int'(k);
      end
    end
    if (r < 1) r = 1;
    if (r > top) r = top;
    j = 0;
    while (j + 1 < n && idx[j] < r) j++;
    if (idx[j] == r || j == 0) col = col_q[j];
    else begin
      a = col_q[j-1];
      b = col_q[j];
      if (meth_q[j-1] == METH_UPPER) col = b;
      else if (meth_q[j-1] == METH_LOWER) col = a;
      else begin
        nr = r - idx[j-1];
        for (int sh = 0; sh <= 16; sh += 8) begin
          ca = int'((a >> sh) & 8'hFF);
          df = int'((b >> sh) & 8'hFF) - ca;
          c = ca + (df * nr) / int'(s);
          if (c < 0) c = 0;
          if (c > 255) c = 255;
          col[sh +: 8] = c[7:0];
        end
      end
    end
    o.color_index = (r > 255) ? 8'd255 : r[7:0];
    o.out_red = col[23:16];
    o.out_green = col[15:8];
    o.out_blue = col[7:0];
    return o;
  endfunction

  task automatic send_word(in_word_t w);
    repeat (gap_q) @(posedge clk_i);
    in_word_i <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gap_q = no_idle ? 0 : $urandom_range(0, 3);
    if (gap_q != 0) in_valid_i <= 1'b0;
    if (w.cmd == CMD_WRITE) begin
      writes_sent++;
      lim_q[w.entry_index] = w.entry_limit ^ 32'h8000_0000;
      col_q[w.entry_index] = {w.entry_red, w.entry_green, w.entry_blue};
      meth_q[w.entry_index] = (w.entry_method == 2'd3) ? METH_STRETCH : meth_e'(w.entry_method);
    end else begin
      maps_sent++;
      expected_colors.push_back(map_sample(w.sample_value));
    end
  endtask

  task automatic write_entry(int e, logic [31:0] lim, logic [23:0] rgb, logic [1:0] m);
    in_word_t w;
    w = '0;
    w.cmd = CMD_WRITE;
    w.entry_index = 3'(e);
    w.entry_limit = lim;
    {w.entry_red, w.entry_green, w.entry_blue} = rgb;
    w.entry_method = m;
    w.sample_value = $urandom;
    send_word(w);
  endtask

  task automatic map_value(logic [31:0] sv);
    in_word_t w;
    w = '0;
    w.cmd = CMD_MAP;
    w.entry_index = 3'($urandom);
    w.entry_limit = $urandom;
    w.entry_red = 8'($urandom);
    w.entry_green = 8'($urandom);
    w.entry_blue = 8'($urandom);
    w.entry_method = 2'($urandom);
    w.sample_value = sv;
    send_word(w);
  endtask

  task automatic drain();
    if (gap_q == 0) in_valid_i <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // registers only change with the pipeline empty
  task automatic set_regs(logic [3:0] cnt, logic [5:0] st);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_LIMIT_COUNT;
    cfg_wdata_i <= {2'b00, cnt};
    @(posedge clk_i);
    cfg_idx_i <= CFG_STRETCH_STEPS;
    cfg_wdata_i <= st;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_q = cnt;
    steps_q = st;
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_word_o);
      end else if (out_word_o !== expected_colors[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h got %h", expected_colors[0], out_word_o);
        void'(expected_colors.pop_front());
      end else void'(expected_colors.pop_front());
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (hold_rx) out_stall_i <= 1'b1;
    else if (no_idle) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  task automatic test_reset_table();
    map_value(32'h8000_0000);
    map_value(32'h0000_0000);
    map_value(32'h0000_8000);
    map_value(32'h0001_0000);
    map_value(32'h7FFF_FFFF);
  endtask

  task automatic test_directed();
    set_regs(4'd4, 6'd32);
    write_entry(0, 32'hFFFF_0000, 24'h000000, 2'd0);
    write_entry(1, 32'h0000_0000, 24'hFF8000, 2'd1);
    write_entry(2, 32'h0002_0000, 24'h00FF00, 2'd2);
    write_entry(3, 32'h7FFF_FFFF, 24'hFFFFFF, 2'd3);
    map_value(32'h8000_0000);
    map_value(32'hFFFF_0000);
    map_value(32'hFFFF_8000);
    map_value(32'h0000_4000);
    map_value(32'h0001_0000);
    map_value(32'h0003_0000);
    map_value(32'h7FFF_FFFF);
    write_entry(1, 32'h8000_0000, 24'h123456, 2'd0);  // unsorted table
    map_value(32'h0000_0000);
    set_regs(4'd0, 6'd0);   // clamped up
    map_value(32'hFFFF_C000);
    set_regs(4'd15, 6'd63); // clamped down
    map_value(32'h4000_0000);
  endtask

  task automatic test_random(int items);
    for (int i = 0; i < items; i++) begin
      if (i % 300 == 0) begin
        drain();
        set_regs(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
      end
      if ($urandom_range(0, 4) == 0)
        write_entry($urandom_range(0, 7),
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20) << 16,
                    24'($urandom), 2'($urandom));
      else
        map_value(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 22 << 16) - 32'h10000);
    end
  endtask

  task automatic test_back_pressure();
    int held;
    hold_rx = 1'b1;
    no_idle = 1'b1;
    fork
      begin
        for (held = 0; held < 60; held++) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 40; i++) map_value($urandom_range(0, 9 << 16));
    join
    no_idle = 1'b0;
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    for (int i = 0; i < 100; i++) map_value($urandom_range(0, 9 << 16));
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      lim_q[i] = 32'h8000_0000;
      col_q[i] = '0;
      meth_q[i] = METH_STRETCH;
    end
    lim_q[1] = ONE_Q16 ^ 32'h8000_0000;
    col_q[1] = COLOR_WHITE;
    count_q = RST_LIMIT_COUNT;
    steps_q = RST_STRETCH_STEPS;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_table();
    test_directed();
    test_random(1650);
    test_back_pressure();
    test_no_idle();
    drain();
    $display("covered %0d map words, %0d table writes, %0d results checked",
             maps_sent, writes_sent, results_seen);
    if (mismatches == 0 && expected_colors.size() == 0)
      $display("gradual_color_ramp_mapper regression: pass");
    else
      $display("gradual_color_ramp_mapper regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("gradual_color_ramp_mapper regression: fail");
    $finish;
  end

endmodule

/* gradual_color_ramp_mapper.f */
sv/gcrm_pkg.sv
sv/gcrm_front.sv
sv/gcrm_div.sv
sv/gcrm_blend.sv
sv/gradual_color_ramp_mapper.sv
sv/gcrm_checker.sv
tb/tb_gradual_color_ramp_mapper.sv
